/* hdl/oal_pkg.sv */
// Shared constants, request and result types, and cell command types for the list engine.
package oal_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int POS_W       = 7;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int GROUP       = 8;
    localparam int GRP_IDX_W   = $clog2(GROUP);
    localparam int NGROUP      = (CAPACITY + GROUP - 1) / GROUP;
    localparam int NCELL_PAD   = NGROUP * GROUP;

    typedef enum logic [2:0] {
        OP_INS_AT   = 3'd0,
        OP_INS_BACK = 3'd1,
        OP_REM_AT   = 3'd2,
        OP_REM_BACK = 3'd3,
        OP_SEARCH   = 3'd4,
        OP_READ     = 3'd5,
        OP_REPLACE  = 3'd6
    } t_req_op;

    typedef struct packed {
        t_req_op             req_type;
        logic [POS_W-1:0]    position;
        logic [DATA_W-1:0]   item_value;
    } t_in_item;

    typedef struct packed {
        logic                ok;
        logic [POS_W-1:0]    found_position;
        logic [DATA_W-1:0]   read_value;
        logic [POS_W-1:0]    entry_count;
        logic                is_full;
        logic                is_empty;
    } t_out_item;

    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_INSERT,
        ACT_REMOVE,
        ACT_WRITE
    } t_cell_act;

    typedef struct packed {
        t_cell_act               act;
        logic [CMP_W-1:0]        pos;
        logic [CMP_W-1:0]        count;
        logic [VALUE_WIDTH-1:0]  value;
    } t_cell_cmd;

    typedef struct packed {
        logic                    any;
        logic [GRP_IDX_W-1:0]    idx;
        logic [VALUE_WIDTH-1:0]  data;
    } t_grp_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_FINISH
    } t_state;

endpackage

/* hdl/oal_cell.sv */
// One list cell: holds an entry, shifts with its neighbors, flags match and position hit.
module oal_cell (
    input  logic                             i_clk,
    input  logic [oal_pkg::CMP_W-1:0]        i_index,
    input  oal_pkg::t_cell_cmd               i_cmd,
    input  logic                             i_apply,
    input  logic [oal_pkg::VALUE_WIDTH-1:0]  i_lower,
    input  logic [oal_pkg::VALUE_WIDTH-1:0]  i_upper,
    output logic                             o_match,
    output logic                             o_hit,
    output logic [oal_pkg::VALUE_WIDTH-1:0]  o_value
);

    logic [oal_pkg::VALUE_WIDTH-1:0] r_value;
    logic [oal_pkg::VALUE_WIDTH-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_apply) begin
            unique case (i_cmd.act)
                oal_pkg::ACT_INSERT: begin
                    if (i_index > i_cmd.pos) begin
                        n_value = i_lower;
                    end else if (i_index == i_cmd.pos) begin
                        n_value = i_cmd.value;
                    end
                end
                oal_pkg::ACT_REMOVE: begin
                    if (i_index >= i_cmd.pos) begin
                        n_value = i_upper;
                    end
                end
                oal_pkg::ACT_WRITE: begin
                    if (i_index == i_cmd.pos) begin
                        n_value = i_cmd.value;
                    end
                end
                default: begin
                    n_value = r_value;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_match = (r_value == i_cmd.value) && (i_index < i_cmd.count);
    assign o_hit   = (i_index == i_cmd.pos);
    assign o_value = r_value;

endmodule

/* hdl/oal_group.sv */
// Registered reduction of one group of cells: first match and selected entry.
module oal_group (
    input  logic                             i_clk,
    input  logic [oal_pkg::GROUP-1:0]        i_match,
    input  logic [oal_pkg::GROUP-1:0]        i_hit,
    input  logic [oal_pkg::VALUE_WIDTH-1:0]  i_values [oal_pkg::GROUP],
    output oal_pkg::t_grp_res                o_res
);

    oal_pkg::t_grp_res r_res;
    oal_pkg::t_grp_res n_res;

    always_comb begin
        n_res = '0;
        for (int j = oal_pkg::GROUP - 1; j >= 0; j--) begin
            if (i_match[j]) begin
                n_res.any = 1'b1;
                n_res.idx = oal_pkg::GRP_IDX_W'(j);
            end
        end
        for (int j = 0; j < oal_pkg::GROUP; j++) begin
            n_res.data = n_res.data | (i_hit[j] ? i_values[j] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

/* hdl/ordered_array_list_engine_top.sv */
// Ordered list engine: request decode, row of list cells, match reduction and result register.
// A request is registered, then the group reduction registers the match and hit flags
// across the cell row, then the combine and update state loads the result register once
// the output is not stalled. A new request is accepted only after that, in the idle state.
// Reset clears the entry count, the control state and the result valid; cell contents
// are not cleared and are only read after being written.
module ordered_array_list_engine_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  oal_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output oal_pkg::t_out_item o_out_data
);

    localparam int VW = oal_pkg::VALUE_WIDTH;
    localparam int CW = oal_pkg::CMP_W;

    oal_pkg::t_state    r_state;
    oal_pkg::t_state    n_state;
    oal_pkg::t_in_item  r_req;
    logic [oal_pkg::CNT_W-1:0] r_count;
    logic [oal_pkg::CNT_W-1:0] n_count;
    oal_pkg::t_out_item r_out;
    oal_pkg::t_out_item n_out;
    logic               r_out_valid;

    logic               accept;
    logic               load_out;
    logic               apply;

    oal_pkg::t_cell_cmd cmd;
    logic               op_ok;
    logic [CW-1:0]      cnt_ext;
    logic [CW-1:0]      pos_ext;

    logic [oal_pkg::NCELL_PAD-1:0] match;
    logic [oal_pkg::NCELL_PAD-1:0] hit;
    logic [VW-1:0]      values [oal_pkg::NCELL_PAD];
    oal_pkg::t_grp_res  grp_res [oal_pkg::NGROUP];

    logic               found_any;
    logic [CW-1:0]      found_idx;
    logic [VW-1:0]      sel_data;

    assign cnt_ext = CW'(r_count);
    assign pos_ext = CW'(r_req.position);

    // request decode
    always_comb begin
        cmd       = '0;
        cmd.act   = oal_pkg::ACT_HOLD;
        cmd.count = cnt_ext;
        cmd.value = VW'(r_req.item_value);
        cmd.pos   = pos_ext;
        op_ok     = 1'b0;
        n_count   = r_count;
        unique case (r_req.req_type)
            oal_pkg::OP_INS_AT: begin
                op_ok = (cnt_ext < CW'(oal_pkg::CAPACITY)) && (pos_ext <= cnt_ext);
            end
            oal_pkg::OP_INS_BACK: begin
                op_ok   = (cnt_ext < CW'(oal_pkg::CAPACITY));
                cmd.pos = cnt_ext;
            end
            oal_pkg::OP_REM_AT: begin
                op_ok = (pos_ext < cnt_ext);
            end
            oal_pkg::OP_REM_BACK: begin
                op_ok   = (cnt_ext != '0);
                cmd.pos = cnt_ext - CW'(1);
            end
            oal_pkg::OP_READ: begin
                op_ok = (pos_ext < cnt_ext);
                if (!op_ok) begin
                    cmd.pos = cnt_ext - CW'(1);
                end
            end
            oal_pkg::OP_REPLACE: begin
                op_ok = (pos_ext < cnt_ext);
            end
            default: begin
                op_ok = 1'b0;
            end
        endcase
        if (op_ok) begin
            unique case (r_req.req_type)
                oal_pkg::OP_INS_AT, oal_pkg::OP_INS_BACK: begin
                    cmd.act = oal_pkg::ACT_INSERT;
                    n_count = r_count + oal_pkg::CNT_W'(1);
                end
                oal_pkg::OP_REM_AT, oal_pkg::OP_REM_BACK: begin
                    cmd.act = oal_pkg::ACT_REMOVE;
                    n_count = r_count - oal_pkg::CNT_W'(1);
                end
                oal_pkg::OP_REPLACE: begin
                    cmd.act = oal_pkg::ACT_WRITE;
                end
                default: begin
                    cmd.act = oal_pkg::ACT_HOLD;
                end
            endcase
        end
    end

    // cell row
    genvar gi;
    generate
        for (gi = 0; gi < oal_pkg::NCELL_PAD; gi++) begin : g_cell
            if (gi < oal_pkg::CAPACITY) begin : g_real
                logic [VW-1:0] lower;
                logic [VW-1:0] upper;
                if (gi == 0) begin : g_first
                    assign lower = '0;
                end else begin : g_mid_lo
                    assign lower = values[gi-1];
                end
                if (gi == oal_pkg::CAPACITY - 1) begin : g_last
                    assign upper = '0;
                end else begin : g_mid_hi
                    assign upper = values[gi+1];
                end
                oal_cell u_cell (
                    .i_clk   (i_clk),
                    .i_index (CW'(gi)),
                    .i_cmd   (cmd),
                    .i_apply (apply),
                    .i_lower (lower),
                    .i_upper (upper),
                    .o_match (match[gi]),
                    .o_hit   (hit[gi]),
                    .o_value (values[gi])
                );
            end else begin : g_pad
                assign match[gi]  = 1'b0;
                assign hit[gi]    = 1'b0;
                assign values[gi] = '0;
            end
        end

        for (gi = 0; gi < oal_pkg::NGROUP; gi++) begin : g_grp
            logic [VW-1:0] gvals [oal_pkg::GROUP];
            for (genvar gj = 0; gj < oal_pkg::GROUP; gj++) begin : g_v
                assign gvals[gj] = values[gi*oal_pkg::GROUP + gj];
            end
            oal_group u_group (
                .i_clk    (i_clk),
                .i_match  (match[gi*oal_pkg::GROUP +: oal_pkg::GROUP]),
                .i_hit    (hit[gi*oal_pkg::GROUP +: oal_pkg::GROUP]),
                .i_values (gvals),
                .o_res    (grp_res[gi])
            );
        end
    endgenerate

    // combine group results
    always_comb begin
        found_any = 1'b0;
        found_idx = cnt_ext;
        sel_data  = '0;
        for (int g = oal_pkg::NGROUP - 1; g >= 0; g--) begin
            if (grp_res[g].any) begin
                found_any = 1'b1;
                found_idx = CW'(g * oal_pkg::GROUP) + CW'(grp_res[g].idx);
            end
        end
        for (int g = 0; g < oal_pkg::NGROUP; g++) begin
            sel_data = sel_data | grp_res[g].data;
        end
    end

    always_comb begin
        n_out                = '0;
        n_out.entry_count    = oal_pkg::POS_W'(n_count);
        n_out.is_full        = (n_count == oal_pkg::CNT_W'(oal_pkg::CAPACITY));
        n_out.is_empty       = (n_count == '0);
        n_out.ok             = op_ok;
        if (r_req.req_type == oal_pkg::OP_SEARCH) begin
            n_out.ok             = found_any;
            n_out.found_position = oal_pkg::POS_W'(found_idx);
        end
        if (r_req.req_type == oal_pkg::OP_READ && r_count != '0) begin
            n_out.read_value = oal_pkg::DATA_W'(sel_data);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            oal_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = oal_pkg::ST_REDUCE;
                end
            end
            oal_pkg::ST_REDUCE: begin
                n_state = oal_pkg::ST_FINISH;
            end
            oal_pkg::ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = oal_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = oal_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = 1'b1;
        load_out   = 1'b0;
        unique case (r_state)
            oal_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            oal_pkg::ST_FINISH: begin
                load_out = !r_out_valid || !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign accept = i_in_valid && !o_in_stall;
    assign apply  = load_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= oal_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_data;
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* verif/ordered_array_list_engine_top_test.sv */
// Self-checking testbench for the ordered list engine with its own list predictor and random traffic.
module ordered_array_list_engine_top_test;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    oal_pkg::t_in_item  in_data   = '0;
    logic               out_stall = 1'b0;
    logic               in_stall;
    logic               out_valid;
    oal_pkg::t_out_item out_data;

    logic [oal_pkg::VALUE_WIDTH-1:0] list_words [oal_pkg::CAPACITY];
    int                 list_len = 0;
    oal_pkg::t_out_item pending_results [$];
    oal_pkg::t_out_item want;
    int         idle_pct = 0;
    int         stall_hold = 0;
    int         requests_sent = 0;
    int         results_checked = 0;
    int         err_count = 0;
    int         full_hits = 0;
    int         empty_hits = 0;

    ordered_array_list_engine_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic int idle_span();
        if ($urandom_range(9) == 0)
            return $urandom_range(30, 8);
        return $urandom_range(3, 1);
    endfunction

    function automatic bit list_insert(input int at,
                                       input logic [oal_pkg::VALUE_WIDTH-1:0] v);
        if (list_len >= oal_pkg::CAPACITY || at > list_len)
            return 1'b0;
        for (int i = list_len; i > at; i--)
            list_words[i] = list_words[i - 1];
        list_words[at] = v;
        list_len++;
        return 1'b1;
    endfunction

    function automatic bit list_remove(input int at);
        if (at >= list_len)
            return 1'b0;
        for (int i = at; i + 1 < list_len; i++)
            list_words[i] = list_words[i + 1];
        list_len--;
        return 1'b1;
    endfunction

    // Applies one request to the shadow list and returns the result it should produce.
    function automatic oal_pkg::t_out_item apply_request(input oal_pkg::t_in_item req);
        oal_pkg::t_out_item r;
        int                 p;
        r = '0;
        p = int'(req.position);
        case (req.req_type)
            oal_pkg::OP_INS_AT:   r.ok = list_insert(p, req.item_value);
            oal_pkg::OP_INS_BACK: r.ok = list_insert(list_len, req.item_value);
            oal_pkg::OP_REM_AT:   r.ok = list_remove(p);
            oal_pkg::OP_REM_BACK: begin
                if (list_len > 0)
                    r.ok = list_remove(list_len - 1);
            end
            oal_pkg::OP_SEARCH: begin
                r.found_position = list_len[oal_pkg::POS_W-1:0];
                for (int i = list_len - 1; i >= 0; i--) begin
                    if (list_words[i] == req.item_value) begin
                        r.ok = 1'b1;
                        r.found_position = i[oal_pkg::POS_W-1:0];
                    end
                end
            end
            oal_pkg::OP_READ: begin
                if (p < list_len) begin
                    r.read_value = list_words[p];
                    r.ok = 1'b1;
                end else if (list_len > 0) begin
                    r.read_value = list_words[list_len - 1];
                end
            end
            oal_pkg::OP_REPLACE: begin
                if (p < list_len) begin
                    list_words[p] = req.item_value;
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.entry_count = list_len[oal_pkg::POS_W-1:0];
        r.is_full     = (list_len >= oal_pkg::CAPACITY);
        r.is_empty    = (list_len == 0);
        if (r.is_full)
            full_hits++;
        if (r.is_empty)
            empty_hits++;
        return r;
    endfunction

    function automatic oal_pkg::t_in_item make_req(input oal_pkg::t_req_op op, input int pos,
                                                   input logic [oal_pkg::DATA_W-1:0] v);
        oal_pkg::t_in_item q;
        q.req_type   = op;
        q.position   = pos[oal_pkg::POS_W-1:0];
        q.item_value = v;
        return q;
    endfunction

    function automatic logic [oal_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [oal_pkg::DATA_W-1:0] pick_search_value();
        if (list_len > 0 && $urandom_range(2) != 0)
            return list_words[$urandom_range(list_len - 1)];
        return pick_value();
    endfunction

    function automatic int pick_position(input bit for_insert);
        int top;
        top = for_insert ? list_len : list_len - 1;
        if (top < 0 || $urandom_range(9) == 0)
            return $urandom_range(oal_pkg::CAPACITY);
        return $urandom_range(top);
    endfunction

    // Called just after a rising edge; returns just after the edge that took the request.
    task automatic send_request(input oal_pkg::t_in_item req);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? idle_span() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(apply_request(req));
        requests_sent++;
    endtask

    always @(posedge clk) begin
        if (stall_hold > 0) begin
            stall_hold--;
        end else begin
            out_stall  <= ($urandom_range(99) < idle_pct);
            stall_hold = idle_span();
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result: %p", out_data);
            end else begin
                want = pending_results.pop_front();
                if (out_data.ok !== want.ok
                        || out_data.found_position !== want.found_position
                        || out_data.read_value !== want.read_value
                        || out_data.entry_count !== want.entry_count
                        || out_data.is_full !== want.is_full
                        || out_data.is_empty !== want.is_empty) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("result %0d mismatch: expected ok=%0b pos=%0d rd=%h %s",
                                 results_checked, want.ok, want.found_position,
                                 want.read_value, "");
                        $display("    expected cnt=%0d full=%0b empty=%0b",
                                 want.entry_count, want.is_full, want.is_empty);
                        $display("    got ok=%0b pos=%0d rd=%h cnt=%0d full=%0b empty=%0b",
                                 out_data.ok, out_data.found_position,
                                 out_data.read_value, out_data.entry_count,
                                 out_data.is_full, out_data.is_empty);
                    end
                end
            end
        end
    end

    // Every operation but insert at back against an empty list; all refused.
    task automatic test_empty_list();
        send_request(make_req(oal_pkg::OP_READ, 0, '0));
        send_request(make_req(oal_pkg::OP_REM_AT, 0, '0));
        send_request(make_req(oal_pkg::OP_REM_BACK, 0, '0));
        send_request(make_req(oal_pkg::OP_SEARCH, 0, '0));
        send_request(make_req(oal_pkg::OP_REPLACE, 0, '1));
        send_request(make_req(oal_pkg::OP_INS_AT, 1, '1));
    endtask

    task automatic test_basic_ops();
        send_request(make_req(oal_pkg::OP_INS_BACK, 0, 32'hFFFF_FFFF));
        send_request(make_req(oal_pkg::OP_INS_AT, 0, 32'h0000_0000));
        send_request(make_req(oal_pkg::OP_INS_AT, 1, 32'hA5A5_A5A5));
        send_request(make_req(oal_pkg::OP_INS_AT, 3, 32'h5A5A_5A5A));
        send_request(make_req(oal_pkg::OP_INS_AT, 5, 32'h1111_1111));
        send_request(make_req(oal_pkg::OP_READ, 2, '0));
        send_request(make_req(oal_pkg::OP_READ, oal_pkg::CAPACITY, '0));
        send_request(make_req(oal_pkg::OP_SEARCH, 0, 32'hA5A5_A5A5));
        send_request(make_req(oal_pkg::OP_SEARCH, 0, 32'h1234_5678));
        send_request(make_req(oal_pkg::OP_REPLACE, 0, 32'hA5A5_A5A5));
        send_request(make_req(oal_pkg::OP_SEARCH, 0, 32'hA5A5_A5A5));
        send_request(make_req(oal_pkg::OP_REPLACE, 4, '0));
        send_request(make_req(oal_pkg::OP_REM_AT, 4, '0));
        send_request(make_req(oal_pkg::OP_REM_AT, 1, '0));
        send_request(make_req(oal_pkg::OP_REM_BACK, 0, '0));
        send_request(make_req(oal_pkg::OP_READ, 0, '0));
    endtask

    // Grow to capacity, hit the full-list corners, then shrink back to empty.
    task automatic test_fill_and_drain();
        while (list_len < oal_pkg::CAPACITY) begin
            if ($urandom_range(3) == 0)
                send_request(make_req(oal_pkg::OP_INS_BACK, $urandom_range(oal_pkg::CAPACITY),
                                      pick_value()));
            else
                send_request(make_req(oal_pkg::OP_INS_AT, $urandom_range(list_len),
                                      pick_value()));
            if ($urandom_range(7) == 0)
                send_request(make_req(oal_pkg::OP_READ, $urandom_range(list_len - 1),
                                      $urandom));
        end
        send_request(make_req(oal_pkg::OP_INS_AT, oal_pkg::CAPACITY, pick_value()));
        send_request(make_req(oal_pkg::OP_INS_BACK, 0, pick_value()));
        send_request(make_req(oal_pkg::OP_READ, oal_pkg::CAPACITY, '0));
        send_request(make_req(oal_pkg::OP_READ, oal_pkg::CAPACITY - 1, '0));
        send_request(make_req(oal_pkg::OP_SEARCH, 0, list_words[oal_pkg::CAPACITY - 1]));
        send_request(make_req(oal_pkg::OP_SEARCH, 0, $urandom));
        send_request(make_req(oal_pkg::OP_REPLACE, oal_pkg::CAPACITY - 1, '1));
        send_request(make_req(oal_pkg::OP_REM_AT, oal_pkg::CAPACITY, '0));
        while (list_len > 0) begin
            if ($urandom_range(3) == 0)
                send_request(make_req(oal_pkg::OP_REM_BACK, $urandom_range(oal_pkg::CAPACITY),
                                      $urandom));
            else
                send_request(make_req(oal_pkg::OP_REM_AT, $urandom_range(list_len - 1),
                                      $urandom));
            if ($urandom_range(7) == 0)
                send_request(make_req(oal_pkg::OP_SEARCH, 0, pick_search_value()));
        end
        send_request(make_req(oal_pkg::OP_REM_BACK, 0, '0));
    endtask

    task automatic test_random_mix(input int n, input int grow_pct, input int shrink_pct);
        int               r;
        oal_pkg::t_req_op op;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < grow_pct) begin
                op = $urandom_range(1) ? oal_pkg::OP_INS_AT : oal_pkg::OP_INS_BACK;
            end else if (r < grow_pct + shrink_pct) begin
                op = $urandom_range(1) ? oal_pkg::OP_REM_AT : oal_pkg::OP_REM_BACK;
            end else begin
                case ($urandom_range(2))
                    0:       op = oal_pkg::OP_SEARCH;
                    1:       op = oal_pkg::OP_READ;
                    default: op = oal_pkg::OP_REPLACE;
                endcase
            end
            send_request(make_req(op,
                                  pick_position(op == oal_pkg::OP_INS_AT
                                                || op == oal_pkg::OP_INS_BACK),
                                  (op == oal_pkg::OP_SEARCH) ? pick_search_value()
                                                             : pick_value()));
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_pct = 20;
        test_empty_list();
        test_basic_ops();
        idle_pct = 30;
        test_fill_and_drain();
        idle_pct = 0;
        test_random_mix(250, 45, 25);
        idle_pct = 40;
        test_random_mix(250, 30, 30);
        idle_pct = 0;
        test_fill_and_drain();
        idle_pct = 15;
        test_random_mix(250, 25, 45);
        idle_pct = 60;
        test_random_mix(250, 60, 20);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("%0d requests of all seven kinds sent, %0d results checked, %0d mismatches",
                 requests_sent, results_checked, err_count);
        $display("list at capacity after %0d requests and empty after %0d, with random stalls",
                 full_hits, empty_hits);
        if (err_count == 0)
            $display("ordered_array_list_engine_top verification clean");
        else
            $display("ordered_array_list_engine_top verification failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("ordered_array_list_engine_top verification failed");
        $finish;
    end

endmodule
